@@ hdl/ucer_pkg.sv @@
// ----------------------------------------------------------------------------
// ucer_pkg
// Types, codes and constant tables shared by the endpoint 0 responder.
// ----------------------------------------------------------------------------
package ucer_pkg;

  // Event kinds carried on the input tuser
  localparam logic [2:0] MODE_SETUP     = 3'd0;
  localparam logic [2:0] MODE_IN_EP0    = 3'd1;
  localparam logic [2:0] MODE_OUT_EP0   = 3'd2;
  localparam logic [2:0] MODE_IN_EP2    = 3'd3;
  localparam logic [2:0] MODE_BUS_RESET = 3'd4;

  // Standard and vendor request codes
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
  localparam logic [7:0] RTYPE_VENDOR_READ     = 8'hC0;
  localparam logic [7:0] RTYPE_VENDOR_WRITE    = 8'h40;
  localparam logic [7:0] REQ_NONE              = 8'hFF;
  localparam logic [7:0] DESC_TYPE_DEVICE      = 8'd1;
  localparam logic [7:0] DESC_TYPE_CONFIG      = 8'd2;
  localparam logic [6:0] SETUP_LENGTH          = 7'd8;

  // Handshake and toggle codes
  localparam logic [1:0] RX_KEEP   = 2'd0;
  localparam logic [1:0] RX_ACK    = 2'd1;
  localparam logic [1:0] RX_STALL  = 2'd2;
  localparam logic [1:0] TX_KEEP   = 2'd0;
  localparam logic [1:0] TX_ACK    = 2'd1;
  localparam logic [1:0] TX_NAK    = 2'd2;
  localparam logic [1:0] TX_STALL  = 2'd3;
  localparam logic [1:0] TOG_KEEP  = 2'd0;
  localparam logic [1:0] TOG_SET   = 2'd1;
  localparam logic [1:0] TOG_CLEAR = 2'd2;
  localparam logic [1:0] TOG_FLIP  = 2'd3;

  // Descriptor layout
  localparam int          CHUNK_BYTES  = 8;
  localparam logic [7:0]  DEV_DESC_LEN = 8'd18;
  localparam logic [7:0]  CFG_DESC_LEN = 8'd39;
  localparam logic [5:0]  DEV_DESC_BASE = 6'd0;
  localparam logic [5:0]  CFG_DESC_BASE = 6'd18;
  localparam logic [5:0]  ROM_TOTAL     = 6'd57;

  // Vendor table
  localparam logic [5:0]  VENDOR_TABLE_BYTES = 6'd26;
  localparam logic [4:0]  CURSOR_STOP        = 5'd24;

  // Classified commands passed from front to back
  typedef logic [3:0] cmd_code_t;
  localparam cmd_code_t CMD_NONE       = 4'd0;
  localparam cmd_code_t CMD_SETUP_BAD  = 4'd1;
  localparam cmd_code_t CMD_STALL_REQ  = 4'd2;
  localparam cmd_code_t CMD_VENDOR_RD  = 4'd3;
  localparam cmd_code_t CMD_VENDOR_WR  = 4'd4;
  localparam cmd_code_t CMD_GET_DEV    = 4'd5;
  localparam cmd_code_t CMD_GET_CFG    = 4'd6;
  localparam cmd_code_t CMD_SET_ADDR   = 4'd7;
  localparam cmd_code_t CMD_GET_CONF   = 4'd8;
  localparam cmd_code_t CMD_SET_CONF   = 4'd9;
  localparam cmd_code_t CMD_IN_EP0     = 4'd10;
  localparam cmd_code_t CMD_OUT_EP0    = 4'd11;
  localparam cmd_code_t CMD_IN_EP2     = 4'd12;
  localparam cmd_code_t CMD_BUS_RESET  = 4'd13;

  typedef struct packed {
    cmd_code_t  code;
    logic [7:0] request_code;
    logic [7:0] value_low;
    logic [7:0] length_low;
  } cmd_t;

  // Result item; last member sits in the lowest bits
  typedef struct packed {
    logic        ep2_rearm;
    logic [6:0]  device_address;
    logic [63:0] ep0_tx_data;
    logic [3:0]  ep0_tx_length;
    logic        ep0_length_write;
    logic [1:0]  ep0_toggle;
    logic [1:0]  ep0_tx_reply;
    logic [1:0]  ep0_rx_reply;
  } result_t;

  localparam logic [7:0] DESC_ROM [64] = '{
    8'h12, 8'h01, 8'h10, 8'h01, 8'h02, 8'h00, 8'h02, 8'h08,
    8'h86, 8'h1A, 8'h23, 8'h75, 8'h04, 8'h03, 8'h00, 8'h00,
    8'h00, 8'h01,
    8'h09, 8'h02, 8'h27, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'hF0,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h03, 8'h02, 8'h01, 8'h02, 8'h00,
    8'h07, 8'h05, 8'h82, 8'h02, 8'h20, 8'h00, 8'h00,
    8'h07, 8'h05, 8'h02, 8'h02, 8'h20, 8'h00, 8'h00,
    8'h07, 8'h05, 8'h81, 8'h03, 8'h08, 8'h00, 8'h01,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] VENDOR_TABLE [32] = '{
    8'h30, 8'h00, 8'hC3, 8'h00, 8'hFF, 8'hEC, 8'h9F, 8'hEC,
    8'hFF, 8'hEC, 8'hDF, 8'hEC, 8'hDF, 8'hEC, 8'hDF, 8'hEC,
    8'h9F, 8'hEC, 8'h9F, 8'hEC, 8'h9F, 8'hEC, 8'h9F, 8'hEC,
    8'hFF, 8'hEC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Descriptor byte; past the end of the descriptors reads zero
  function automatic logic [7:0] rom_byte(input logic [5:0] pos);
    return (pos < ROM_TOTAL) ? DESC_ROM[pos] : 8'h00;
  endfunction

  // Vendor byte; index runs one past the cursor range
  function automatic logic [7:0] vendor_byte(input logic [5:0] idx);
    return (idx < VENDOR_TABLE_BYTES) ? VENDOR_TABLE[idx[4:0]] : 8'h00;
  endfunction

endpackage

@@ hdl/ucer_front.sv @@
// ----------------------------------------------------------------------------
// ucer_front
// Decodes one token event and its setup fields into a command.
// ----------------------------------------------------------------------------
module ucer_front (
  input  logic [2:0]    mode,
  input  logic [6:0]    rx_length,
  input  logic [7:0]    request_type,
  input  logic [7:0]    request_code,
  input  logic [7:0]    value_low,
  input  logic [7:0]    value_high,
  input  logic [7:0]    length_low,
  output ucer_pkg::cmd_t cmd
);

  ucer_pkg::cmd_code_t code;

  // Classify the token event and, for a setup, its request
  always_comb begin
    code = ucer_pkg::CMD_NONE;
    priority if (mode == ucer_pkg::MODE_SETUP) begin
      priority if (rx_length != ucer_pkg::SETUP_LENGTH) begin
        code = ucer_pkg::CMD_SETUP_BAD;
      end else if (request_type == ucer_pkg::RTYPE_VENDOR_READ) begin
        code = ucer_pkg::CMD_VENDOR_RD;
      end else if (request_type == ucer_pkg::RTYPE_VENDOR_WRITE) begin
        code = ucer_pkg::CMD_VENDOR_WR;
      end else if (request_code == ucer_pkg::REQ_GET_DESCRIPTOR) begin
        priority if (value_high == ucer_pkg::DESC_TYPE_DEVICE) begin
          code = ucer_pkg::CMD_GET_DEV;
        end else if (value_high == ucer_pkg::DESC_TYPE_CONFIG) begin
          code = ucer_pkg::CMD_GET_CFG;
        end else begin
          code = ucer_pkg::CMD_STALL_REQ;
        end
      end else if (request_code == ucer_pkg::REQ_SET_ADDRESS) begin
        code = ucer_pkg::CMD_SET_ADDR;
      end else if (request_code == ucer_pkg::REQ_GET_CONFIGURATION) begin
        code = ucer_pkg::CMD_GET_CONF;
      end else if (request_code == ucer_pkg::REQ_SET_CONFIGURATION) begin
        code = ucer_pkg::CMD_SET_CONF;
      end else begin
        code = ucer_pkg::CMD_STALL_REQ;
      end
    end else if (mode == ucer_pkg::MODE_IN_EP0) begin
      code = ucer_pkg::CMD_IN_EP0;
    end else if (mode == ucer_pkg::MODE_OUT_EP0) begin
      code = ucer_pkg::CMD_OUT_EP0;
    end else if (mode == ucer_pkg::MODE_IN_EP2) begin
      code = ucer_pkg::CMD_IN_EP2;
    end else if (mode == ucer_pkg::MODE_BUS_RESET) begin
      code = ucer_pkg::CMD_BUS_RESET;
    end else begin
      code = ucer_pkg::CMD_NONE;
    end
  end

  // Bundle the command with the setup bytes the back end needs
  assign cmd.code         = code;
  assign cmd.request_code = request_code;
  assign cmd.value_low    = value_low;
  assign cmd.length_low   = length_low;

endmodule

@@ hdl/ucer_queue.sv @@
// ----------------------------------------------------------------------------
// ucer_queue
// Two-entry command queue between the decoder and the executor.
// ----------------------------------------------------------------------------
module ucer_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ucer_pkg::cmd_t push_cmd,
  output logic           not_full,
  input  logic           pop,
  output logic           not_empty,
  output ucer_pkg::cmd_t pop_cmd
);

  ucer_pkg::cmd_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_cmd   = entry[rd_ptr];

  // Store incoming commands
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/ucer_back.sv @@
// ----------------------------------------------------------------------------
// ucer_back
// Executes one command per cycle, while the result register is free or
// draining, against the endpoint state and registers the result beat.
// ----------------------------------------------------------------------------
module ucer_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  ucer_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output ucer_pkg::result_t out_result
);

  logic [4:0] vendor_cursor;
  logic [7:0] stored_request;
  logic [7:0] remaining_length;
  logic [5:0] rom_position;
  logic [7:0] configuration_value;
  logic [6:0] address_register;

  logic [4:0] vendor_cursor_next;
  logic [7:0] stored_request_next;
  logic [7:0] remaining_length_next;
  logic [5:0] rom_position_next;
  logic [7:0] configuration_value_next;
  logic [6:0] address_register_next;

  ucer_pkg::result_t result;

  logic        chunk_use;
  logic [5:0]  chunk_pos;
  logic [7:0]  chunk_rem;
  logic [3:0]  chunk_len;
  logic [63:0] chunk_data;
  logic [7:0]  dev_rem;
  logic [7:0]  cfg_rem;
  logic [5:0]  vendor_idx;

  // Take a command whenever the output register is free or draining
  assign cmd_pop = cmd_valid && (!out_valid || out_ready);

  // Clamp requested lengths to the descriptor sizes
  assign dev_rem = (cmd.length_low > ucer_pkg::DEV_DESC_LEN) ?
                   ucer_pkg::DEV_DESC_LEN : cmd.length_low;
  assign cfg_rem = (cmd.length_low > ucer_pkg::CFG_DESC_LEN) ?
                   ucer_pkg::CFG_DESC_LEN : cmd.length_low;

  // Select where the descriptor chunk starts
  always_comb begin
    chunk_pos = rom_position;
    chunk_rem = remaining_length;
    if (cmd.code == ucer_pkg::CMD_GET_DEV) begin
      chunk_pos = ucer_pkg::DEV_DESC_BASE;
      chunk_rem = dev_rem;
    end else if (cmd.code == ucer_pkg::CMD_GET_CFG) begin
      chunk_pos = ucer_pkg::CFG_DESC_BASE;
      chunk_rem = cfg_rem;
    end
  end

  assign chunk_len = (chunk_rem >= 8'(ucer_pkg::CHUNK_BYTES)) ?
                     4'(ucer_pkg::CHUNK_BYTES) : chunk_rem[3:0];

  // Gather up to eight ROM bytes, zero beyond the chunk length
  always_comb begin
    for (int i = 0; i < ucer_pkg::CHUNK_BYTES; i++) begin
      chunk_data[8*i +: 8] = (4'(i) < chunk_len) ?
                             ucer_pkg::rom_byte(6'(chunk_pos + 6'(i))) : 8'h00;
    end
  end

  assign vendor_idx = {1'b0, vendor_cursor};

  // Execute the command
  always_comb begin
    vendor_cursor_next       = vendor_cursor;
    stored_request_next      = stored_request;
    remaining_length_next    = remaining_length;
    rom_position_next        = rom_position;
    configuration_value_next = configuration_value;
    address_register_next    = address_register;
    result                   = '0;
    chunk_use                = 1'b0;

    unique case (cmd.code)
      ucer_pkg::CMD_SETUP_BAD: begin
        stored_request_next = ucer_pkg::REQ_NONE;
        result.ep0_rx_reply = ucer_pkg::RX_STALL;
        result.ep0_tx_reply = ucer_pkg::TX_STALL;
        result.ep0_toggle   = ucer_pkg::TOG_SET;
      end
      ucer_pkg::CMD_STALL_REQ: begin
        remaining_length_next = cmd.length_low;
        stored_request_next   = ucer_pkg::REQ_NONE;
        result.ep0_rx_reply   = ucer_pkg::RX_STALL;
        result.ep0_tx_reply   = ucer_pkg::TX_STALL;
        result.ep0_toggle     = ucer_pkg::TOG_SET;
      end
      ucer_pkg::CMD_VENDOR_RD, ucer_pkg::CMD_VENDOR_WR, ucer_pkg::CMD_GET_DEV,
      ucer_pkg::CMD_GET_CFG, ucer_pkg::CMD_SET_ADDR, ucer_pkg::CMD_GET_CONF,
      ucer_pkg::CMD_SET_CONF: begin
        remaining_length_next   = cmd.length_low;
        stored_request_next     = cmd.request_code;
        result.ep0_rx_reply     = ucer_pkg::RX_ACK;
        result.ep0_tx_reply     = ucer_pkg::TX_ACK;
        result.ep0_toggle       = ucer_pkg::TOG_SET;
        result.ep0_length_write = 1'b1;
        if (cmd.code == ucer_pkg::CMD_VENDOR_RD) begin
          result.ep0_tx_length = 4'd2;
          result.ep0_tx_data   = {48'h0,
                                  ucer_pkg::vendor_byte(vendor_idx + 6'd1),
                                  ucer_pkg::vendor_byte(vendor_idx)};
          vendor_cursor_next   = (vendor_cursor < ucer_pkg::CURSOR_STOP) ?
                                 vendor_cursor + 5'd2 : ucer_pkg::CURSOR_STOP;
        end else if (cmd.code == ucer_pkg::CMD_GET_DEV ||
                     cmd.code == ucer_pkg::CMD_GET_CFG) begin
          chunk_use = 1'b1;
        end else if (cmd.code == ucer_pkg::CMD_SET_ADDR) begin
          remaining_length_next = cmd.value_low;
        end else if (cmd.code == ucer_pkg::CMD_GET_CONF) begin
          if (cmd.length_low != 8'd0) begin
            result.ep0_tx_length = 4'd1;
            result.ep0_tx_data   = {56'h0, configuration_value};
          end
        end else if (cmd.code == ucer_pkg::CMD_SET_CONF) begin
          configuration_value_next = cmd.value_low;
        end
      end
      ucer_pkg::CMD_IN_EP0: begin
        priority if (stored_request == ucer_pkg::REQ_GET_DESCRIPTOR) begin
          chunk_use               = 1'b1;
          result.ep0_length_write = 1'b1;
          result.ep0_toggle       = ucer_pkg::TOG_FLIP;
        end else if (stored_request == ucer_pkg::REQ_SET_ADDRESS) begin
          address_register_next = remaining_length[6:0];
          result.ep0_rx_reply   = ucer_pkg::RX_ACK;
          result.ep0_tx_reply   = ucer_pkg::TX_NAK;
          result.ep0_toggle     = ucer_pkg::TOG_CLEAR;
        end else begin
          result.ep0_length_write = 1'b1;
          result.ep0_rx_reply     = ucer_pkg::RX_ACK;
          result.ep0_tx_reply     = ucer_pkg::TX_NAK;
          result.ep0_toggle       = ucer_pkg::TOG_CLEAR;
        end
      end
      ucer_pkg::CMD_OUT_EP0: begin
        result.ep0_length_write = 1'b1;
        result.ep0_rx_reply     = ucer_pkg::RX_ACK;
        result.ep0_tx_reply     = ucer_pkg::TX_ACK;
        result.ep0_toggle       = ucer_pkg::TOG_CLEAR;
      end
      ucer_pkg::CMD_IN_EP2: begin
        result.ep2_rearm = 1'b1;
      end
      ucer_pkg::CMD_BUS_RESET: begin
        address_register_next = 7'd0;
      end
      default: begin
      end
    endcase

    // Send a descriptor chunk and advance the ROM window
    if (chunk_use) begin
      result.ep0_tx_length  = chunk_len;
      result.ep0_tx_data    = chunk_data;
      remaining_length_next = chunk_rem - {4'd0, chunk_len};
      rom_position_next     = 6'(chunk_pos + {2'd0, chunk_len});
    end

    result.device_address = address_register_next;
  end

  // Update endpoint state on each executed command
  always_ff @(posedge clk) begin
    if (rst) begin
      vendor_cursor       <= 5'd0;
      stored_request      <= 8'd0;
      remaining_length    <= 8'd0;
      rom_position        <= 6'd0;
      configuration_value <= 8'd0;
      address_register    <= 7'd0;
    end else if (cmd_pop) begin
      vendor_cursor       <= vendor_cursor_next;
      stored_request      <= stored_request_next;
      remaining_length    <= remaining_length_next;
      rom_position        <= rom_position_next;
      configuration_value <= configuration_value_next;
      address_register    <= address_register_next;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      out_result <= result;
    end
  end

  // Vendor cursor walks even positions and parks at its stop
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (vendor_cursor[0] == 1'b0) && (vendor_cursor <= ucer_pkg::CURSOR_STOP))
    else $error("vendor cursor out of range");

  // A bus reset leaves the address cleared
  a_bus_reset: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && cmd.code == ucer_pkg::CMD_BUS_RESET) |=>
      (address_register == 7'd0 && out_result.device_address == 7'd0))
    else $error("address not cleared by bus reset");

  // Transmit length never exceeds one chunk and needs a length write
  a_tx_length: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_result.ep0_tx_length <= 4'(ucer_pkg::CHUNK_BYTES)) &&
                  (out_result.ep0_length_write || out_result.ep0_tx_length == 4'd0))
    else $error("bad transmit length");

  // A stalled result is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result)))
    else $error("pending result lost");

endmodule

@@ hdl/usb_control_endpoint_responder.sv @@
// ----------------------------------------------------------------------------
// usb_control_endpoint_responder
// Endpoint 0 control responder: decodes token events and answers each one
// with one beat of handshake, toggle, length and data actions.
// ----------------------------------------------------------------------------
// Each accepted token event yields exactly one result beat. The block takes
// one event per clock while the queue has room; the event waits in the
// two-entry command queue behind the decoder, then the executor registers
// the result. The executor reads the descriptor ROM for a whole 8-byte
// chunk combinationally, so descriptor transfers run at the same rate as
// every other event. Input stalls only when the queue is full because the
// result beat is held by the consumer.
module usb_control_endpoint_responder (
  input  logic        clk,
  input  logic        rst,
  // tuser: mode[2:0]
  // tdata: rx_length[6:0], request_type[14:7], request_code[22:15],
  //        value_low[30:23], value_high[38:31], length_low[46:39], pad[47]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic [2:0]  s_tuser,
  // tdata: ep0_rx_reply[1:0], ep0_tx_reply[3:2], ep0_toggle[5:4],
  //        ep0_length_write[6], ep0_tx_length[10:7], ep0_tx_data[74:11],
  //        device_address[81:75], ep2_rearm[82], pad[87:83]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata
);

  ucer_pkg::cmd_t    front_cmd;
  ucer_pkg::cmd_t    queue_cmd;
  ucer_pkg::result_t result;
  logic              queue_not_full;
  logic              queue_not_empty;
  logic              queue_pop;

  // Decode the incoming event
  ucer_front u_front (
    .mode         (s_tuser),
    .rx_length    (s_tdata[6:0]),
    .request_type (s_tdata[14:7]),
    .request_code (s_tdata[22:15]),
    .value_low    (s_tdata[30:23]),
    .value_high   (s_tdata[38:31]),
    .length_low   (s_tdata[46:39]),
    .cmd          (front_cmd)
  );

  assign s_tready = queue_not_full;

  // Buffer commands between decoder and executor
  ucer_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && queue_not_full),
    .push_cmd  (front_cmd),
    .not_full  (queue_not_full),
    .pop       (queue_pop),
    .not_empty (queue_not_empty),
    .pop_cmd   (queue_cmd)
  );

  // Execute commands and register results
  ucer_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (queue_not_empty),
    .cmd        (queue_cmd),
    .cmd_pop    (queue_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  assign m_tdata = {5'd0, result};

endmodule

@@ sim/usb_control_endpoint_responder_test.sv @@
// ----------------------------------------------------------------------------
// usb_control_endpoint_responder_test
// Drives token events into the endpoint 0 responder and checks every result
// beat field by field against a cycle-free behavioral predictor. A directed
// run covers the setup, descriptor, address, configuration, vendor and
// ignored-event cases; random control transfers and noise follow, with
// random gaps on both sides, one long consumer stall and two drain pauses.
// ----------------------------------------------------------------------------
module usb_control_endpoint_responder_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_STOP = 1830;

  typedef struct packed {
    logic       hold_for_drain;
    logic [2:0] mode;
    logic [6:0] rx_length;
    logic [7:0] request_type;
    logic [7:0] request_code;
    logic [7:0] value_low;
    logic [7:0] value_high;
    logic [7:0] length_low;
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;

  usb_control_endpoint_responder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  token_t            pending_tokens[$];
  ucer_pkg::result_t expected_responses[$];
  int                errors = 0;
  int                cycles = 0;
  logic              drain_next = 1'b0;

  // Predictor state
  logic [4:0] vend_cursor = '0;
  logic [7:0] pending_request = '0;
  logic [7:0] bytes_left = '0;
  logic [5:0] rom_pos = '0;
  logic [7:0] config_value = '0;
  logic [6:0] dev_addr = '0;

  // Short gaps mostly, a few long ones, and idle-free stretches
  function automatic int pick_gap(input int progress);
    int roll;
    if ((progress / 150) % 4 == 3) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] vendor_entry(input logic [5:0] idx);
    return (idx < ucer_pkg::VENDOR_TABLE_BYTES) ? ucer_pkg::VENDOR_TABLE[idx[4:0]] : 8'h00;
  endfunction

  // Emit the next descriptor chunk and advance the ROM pointer
  function automatic logic [3:0] take_chunk(output logic [63:0] chunk);
    logic [3:0] n;
    logic [5:0] pos;
    n = (bytes_left >= 8'd8) ? 4'd8 : bytes_left[3:0];
    chunk = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < n) begin
        pos = rom_pos + 6'(i);
        chunk[8*i +: 8] = (pos < ucer_pkg::ROM_TOTAL) ? ucer_pkg::DESC_ROM[pos] : 8'h00;
      end
    end
    bytes_left = bytes_left - 8'(n);
    rom_pos = rom_pos + 6'(n);
    return n;
  endfunction

  // Work out the response to one token event and update the device state
  function automatic ucer_pkg::result_t respond(input token_t t);
    ucer_pkg::result_t r;
    logic              stall;
    logic [3:0]        len;
    logic [63:0]       data;
    logic [7:0]        desc_len;
    r = '0;
    stall = 1'b0;
    len = '0;
    data = '0;
    desc_len = '0;
    case (t.mode)
      ucer_pkg::MODE_SETUP: begin
        if (t.rx_length != ucer_pkg::SETUP_LENGTH) begin
          stall = 1'b1;
        end else begin
          bytes_left = t.length_low;
          pending_request = t.request_code;
          if (t.request_type == ucer_pkg::RTYPE_VENDOR_READ) begin
            data[7:0] = vendor_entry({1'b0, vend_cursor});
            data[15:8] = vendor_entry({1'b0, vend_cursor} + 6'd1);
            len = 4'd2;
            if (vend_cursor < ucer_pkg::CURSOR_STOP) vend_cursor = vend_cursor + 5'd2;
            else vend_cursor = ucer_pkg::CURSOR_STOP;
          end else if (t.request_type == ucer_pkg::RTYPE_VENDOR_WRITE) begin
            len = 4'd0;
          end else if (t.request_code == ucer_pkg::REQ_GET_DESCRIPTOR) begin
            if (t.value_high == ucer_pkg::DESC_TYPE_DEVICE) begin
              rom_pos = ucer_pkg::DEV_DESC_BASE;
              desc_len = ucer_pkg::DEV_DESC_LEN;
            end else if (t.value_high == ucer_pkg::DESC_TYPE_CONFIG) begin
              rom_pos = ucer_pkg::CFG_DESC_BASE;
              desc_len = ucer_pkg::CFG_DESC_LEN;
            end else begin
              stall = 1'b1;
            end
            if (!stall) begin
              if (bytes_left > desc_len) bytes_left = desc_len;
              len = take_chunk(data);
            end
          end else if (t.request_code == ucer_pkg::REQ_SET_ADDRESS) begin
            bytes_left = t.value_low;
          end else if (t.request_code == ucer_pkg::REQ_GET_CONFIGURATION) begin
            if (bytes_left >= 8'd1) begin
              len = 4'd1;
              data = {56'd0, config_value};
            end
          end else if (t.request_code == ucer_pkg::REQ_SET_CONFIGURATION) begin
            config_value = t.value_low;
          end else begin
            stall = 1'b1;
          end
        end
        r.ep0_toggle = ucer_pkg::TOG_SET;
        if (stall) begin
          pending_request = ucer_pkg::REQ_NONE;
          r.ep0_rx_reply = ucer_pkg::RX_STALL;
          r.ep0_tx_reply = ucer_pkg::TX_STALL;
        end else begin
          r.ep0_rx_reply = ucer_pkg::RX_ACK;
          r.ep0_tx_reply = ucer_pkg::TX_ACK;
          r.ep0_length_write = 1'b1;
          r.ep0_tx_length = len;
          r.ep0_tx_data = data;
        end
      end
      ucer_pkg::MODE_IN_EP0: begin
        if (pending_request == ucer_pkg::REQ_GET_DESCRIPTOR) begin
          r.ep0_tx_length = take_chunk(data);
          r.ep0_tx_data = data;
          r.ep0_length_write = 1'b1;
          r.ep0_toggle = ucer_pkg::TOG_FLIP;
        end else if (pending_request == ucer_pkg::REQ_SET_ADDRESS) begin
          dev_addr = bytes_left[6:0];
          r.ep0_rx_reply = ucer_pkg::RX_ACK;
          r.ep0_tx_reply = ucer_pkg::TX_NAK;
          r.ep0_toggle = ucer_pkg::TOG_CLEAR;
        end else begin
          r.ep0_length_write = 1'b1;
          r.ep0_rx_reply = ucer_pkg::RX_ACK;
          r.ep0_tx_reply = ucer_pkg::TX_NAK;
          r.ep0_toggle = ucer_pkg::TOG_CLEAR;
        end
      end
      ucer_pkg::MODE_OUT_EP0: begin
        r.ep0_length_write = 1'b1;
        r.ep0_rx_reply = ucer_pkg::RX_ACK;
        r.ep0_tx_reply = ucer_pkg::TX_ACK;
        r.ep0_toggle = ucer_pkg::TOG_CLEAR;
      end
      ucer_pkg::MODE_IN_EP2: r.ep2_rearm = 1'b1;
      ucer_pkg::MODE_BUS_RESET: dev_addr = '0;
      default: ;
    endcase
    r.device_address = dev_addr;
    return r;
  endfunction

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(0, 255));
  endfunction

  // Standard request type: anything but the two vendor codes
  function automatic logic [7:0] std_type();
    logic [7:0] v;
    v = rand8();
    if (v == ucer_pkg::RTYPE_VENDOR_READ || v == ucer_pkg::RTYPE_VENDOR_WRITE) v = 8'h80;
    return v;
  endfunction

  task automatic add_token(input logic [2:0] mode, input logic [6:0] rxl,
                           input logic [7:0] rt, input logic [7:0] rc,
                           input logic [7:0] vl, input logic [7:0] vh,
                           input logic [7:0] ll);
    pending_tokens.push_back('{drain_next, mode, rxl, rt, rc, vl, vh, ll});
    drain_next = 1'b0;
  endtask

  task automatic add_setup(input logic [7:0] rt, input logic [7:0] rc,
                           input logic [7:0] vl, input logic [7:0] vh,
                           input logic [7:0] ll);
    add_token(ucer_pkg::MODE_SETUP, ucer_pkg::SETUP_LENGTH, rt, rc, vl, vh, ll);
  endtask

  task automatic add_plain(input logic [2:0] mode);
    add_token(mode, 7'($urandom_range(0, 64)), rand8(), rand8(), rand8(), rand8(),
              rand8());
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Driver: offer pending token beats, predict each one as it is accepted
  token_t cur_token;
  int     send_gap = 0;
  int     accepted_tokens = 0;

  always @(posedge clk) begin : driver
    logic offered;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      offered = s_tvalid;
      if (s_tvalid && s_tready) begin
        expected_responses.push_back(respond(cur_token));
        accepted_tokens++;
        offered = 1'b0;
      end
      if (!offered) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_tokens.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (pending_tokens[0].hold_for_drain && expected_responses.size() != 0) begin
          s_tvalid <= 1'b0;
        end else begin
          cur_token = pending_tokens.pop_front();
          s_tdata <= {1'b0, cur_token.length_low, cur_token.value_high,
                      cur_token.value_low, cur_token.request_code,
                      cur_token.request_type, cur_token.rx_length};
          s_tuser <= cur_token.mode;
          s_tvalid <= 1'b1;
          send_gap = pick_gap(accepted_tokens);
        end
      end
    end
  end

  // Monitor: check result beats in order, throttle tready
  int   results_seen = 0;
  int   hold_left = 0;
  int   ready_gap = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin : monitor
    ucer_pkg::result_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[82:0];
        results_seen++;
        if (expected_responses.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, actual %0h", $time, got);
        end else begin
          want = expected_responses.pop_front();
          check_field("ep0_rx_reply", want.ep0_rx_reply, got.ep0_rx_reply);
          check_field("ep0_tx_reply", want.ep0_tx_reply, got.ep0_tx_reply);
          check_field("ep0_toggle", want.ep0_toggle, got.ep0_toggle);
          check_field("ep0_length_write", want.ep0_length_write, got.ep0_length_write);
          check_field("ep0_tx_length", want.ep0_tx_length, got.ep0_tx_length);
          check_field("ep0_tx_data", want.ep0_tx_data, got.ep0_tx_data);
          check_field("device_address", want.device_address, got.device_address);
          check_field("ep2_rearm", want.ep2_rearm, got.ep2_rearm);
        end
      end
      // One long stall so the input side backs up
      if (results_seen == 500 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        ready_gap = ($urandom_range(0, 3) == 0) ? pick_gap(results_seen) : 0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int         roll;
    int         n;
    logic [7:0] vh;
    logic [7:0] ll;
    logic       mid_drain_done;
    mid_drain_done = 1'b0;

    // Directed: bad setup lengths, both descriptors to their ends,
    // unknown descriptor type, address, configuration, vendor, others
    add_token(ucer_pkg::MODE_SETUP, 7'd0, 8'h80, ucer_pkg::REQ_GET_DESCRIPTOR, 8'h00,
              ucer_pkg::DESC_TYPE_DEVICE, 8'h12);
    add_plain(ucer_pkg::MODE_IN_EP0);
    add_token(ucer_pkg::MODE_SETUP, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_setup(8'h80, ucer_pkg::REQ_GET_DESCRIPTOR, 8'h00, ucer_pkg::DESC_TYPE_DEVICE, 8'hFF);
    repeat (3) add_plain(ucer_pkg::MODE_IN_EP0);
    add_plain(ucer_pkg::MODE_OUT_EP0);
    add_setup(8'h80, ucer_pkg::REQ_GET_DESCRIPTOR, 8'h00, ucer_pkg::DESC_TYPE_CONFIG, 8'hFF);
    repeat (5) add_plain(ucer_pkg::MODE_IN_EP0);
    add_setup(8'h80, ucer_pkg::REQ_GET_DESCRIPTOR, 8'h00, 8'h03, 8'h40);
    add_setup(8'h80, ucer_pkg::REQ_GET_DESCRIPTOR, 8'h00, ucer_pkg::DESC_TYPE_DEVICE, 8'h00);
    add_setup(8'h00, ucer_pkg::REQ_SET_ADDRESS, 8'hFF, 8'h00, 8'h00);
    add_plain(ucer_pkg::MODE_IN_EP0);
    add_setup(8'h00, ucer_pkg::REQ_SET_CONFIGURATION, 8'hFF, 8'h00, 8'h00);
    add_setup(8'h80, ucer_pkg::REQ_GET_CONFIGURATION, 8'h00, 8'h00, 8'h00);
    add_setup(8'h80, ucer_pkg::REQ_GET_CONFIGURATION, 8'h00, 8'h00, 8'h01);
    add_setup(ucer_pkg::RTYPE_VENDOR_WRITE, 8'h01, 8'h00, 8'h00, 8'h00);
    add_setup(ucer_pkg::RTYPE_VENDOR_READ, 8'h01, 8'h00, 8'h00, 8'h02);
    add_setup(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    add_plain(ucer_pkg::MODE_IN_EP2);
    add_plain(ucer_pkg::MODE_BUS_RESET);
    add_token(3'd5, 7'd8, 8'h00, ucer_pkg::REQ_SET_ADDRESS, 8'h12, 8'h00, 8'h00);
    add_token(3'd7, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

    // Random: mostly well-formed control transfers, some noise
    drain_next = 1'b1;
    while (pending_tokens.size() < RANDOM_STOP) begin
      if (pending_tokens.size() > 900 && !mid_drain_done) begin
        drain_next = 1'b1;
        mid_drain_done = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        if ($urandom_range(0, 9) == 0) vh = rand8();
        else vh = $urandom_range(0, 1) ? ucer_pkg::DESC_TYPE_DEVICE
                                       : ucer_pkg::DESC_TYPE_CONFIG;
        ll = ($urandom_range(0, 4) == 0) ? rand8() : 8'($urandom_range(0, 64));
        add_setup(std_type(), ucer_pkg::REQ_GET_DESCRIPTOR, rand8(), vh, ll);
        n = $urandom_range(0, 7);
        repeat (n) add_plain(ucer_pkg::MODE_IN_EP0);
        add_plain(ucer_pkg::MODE_OUT_EP0);
      end else if (roll < 35) begin
        add_setup(std_type(), ucer_pkg::REQ_SET_ADDRESS, rand8(), rand8(), rand8());
        add_plain(ucer_pkg::MODE_IN_EP0);
      end else if (roll < 45) begin
        if ($urandom_range(0, 1)) begin
          add_setup(std_type(), ucer_pkg::REQ_SET_CONFIGURATION, rand8(), rand8(), rand8());
        end else begin
          add_setup(std_type(), ucer_pkg::REQ_GET_CONFIGURATION, rand8(), rand8(),
                    $urandom_range(0, 3) == 0 ? 8'h00 : rand8());
          add_plain(ucer_pkg::MODE_OUT_EP0);
        end
        add_plain(ucer_pkg::MODE_IN_EP0);
      end else if (roll < 55) begin
        add_setup($urandom_range(0, 2) != 0 ? ucer_pkg::RTYPE_VENDOR_READ
                                            : ucer_pkg::RTYPE_VENDOR_WRITE,
                  rand8(), rand8(), rand8(), rand8());
        add_plain($urandom_range(0, 1) ? ucer_pkg::MODE_IN_EP0 : ucer_pkg::MODE_OUT_EP0);
      end else if (roll < 60) begin
        add_plain($urandom_range(0, 1) ? ucer_pkg::MODE_BUS_RESET : ucer_pkg::MODE_IN_EP2);
      end else if (roll < 70) begin
        n = $urandom_range(0, 127);
        if (n == ucer_pkg::SETUP_LENGTH) n = 0;
        add_token(ucer_pkg::MODE_SETUP, 7'(n), rand8(), rand8(), rand8(), rand8(), rand8());
        add_plain($urandom_range(0, 1) ? ucer_pkg::MODE_IN_EP0 : ucer_pkg::MODE_OUT_EP0);
      end else if (roll < 80) begin
        add_plain(3'($urandom_range(1, 2)));
      end else begin
        add_token(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)), rand8(), rand8(),
                  rand8(), rand8(), rand8());
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_tokens.size() != 0 || s_tvalid || expected_responses.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (expected_responses.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, expected_responses.size());
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ usb_control_endpoint_responder.f @@
hdl/ucer_pkg.sv
hdl/ucer_front.sv
hdl/ucer_queue.sv
hdl/ucer_back.sv
hdl/usb_control_endpoint_responder.sv
sim/usb_control_endpoint_responder_test.sv
